@@ rtl/ufp_pkg.sv @@
// Package for the URL-encoded form parser: character constants, escape phase
// codes, result and bundle types, and the hex digit decoder.
// No dependencies.
package ufp_pkg;

  localparam int unsigned MaxResults = 4;
  localparam int unsigned IdxW       = $clog2(MaxResults);
  localparam int unsigned QueueDepth = 4;

  localparam logic [7:0] CharPercent = 8'h25;
  localparam logic [7:0] CharPlus    = 8'h2B;
  localparam logic [7:0] CharEquals  = 8'h3D;
  localparam logic [7:0] CharAmp     = 8'h26;
  localparam logic [7:0] CharSpace   = 8'h20;

  typedef enum logic [2:0] {
    EscIdle    = 3'b001,
    EscPercent = 3'b010,
    EscDigit   = 3'b100
  } esc_e;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       in_value;
    logic       pair_end;
  } result_t;

  typedef struct packed {
    logic [IdxW-1:0]                last_idx;
    result_t [MaxResults-1:0]       res;
  } bundle_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t       h;
    logic [7:0] d;
    h = '0;
    d = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d     = c - 8'h30;
      h.ok  = 1'b1;
      h.val = d[3:0];
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d     = c - 8'h57;
      h.ok  = 1'b1;
      h.val = d[3:0];
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d     = c - 8'h37;
      h.ok  = 1'b1;
      h.val = d[3:0];
    end
    return h;
  endfunction

endpackage

@@ rtl/ufp_if.sv @@
// Valid/ready channel interfaces for the form parser's input and result beats.
// No dependencies.
interface ufp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_data;

  modport source (output valid, output in_byte, output end_of_data, input ready);
  modport sink (input valid, input in_byte, input end_of_data, output ready);
endinterface

interface ufp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       in_value;
  logic       pair_end;
  logic       run_last;

  modport source (output valid, output out_byte, output has_byte, output in_value,
                  output pair_end, output run_last, input ready);
  modport sink (input valid, input out_byte, input has_byte, input in_value,
                input pair_end, input run_last, output ready);
endinterface

@@ rtl/ufp_front.sv @@
// Front end: accepts one encoded byte per beat, tracks the escape and key/value
// state, and forms a bundle of up to four results. Depends on ufp_pkg.
module ufp_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [7:0]       in_byte_i,
  input  logic             in_eod_i,
  output logic             in_ready_o,
  input  logic             full_i,
  output logic             push_o,
  output ufp_pkg::bundle_t bundle_o
);

  ufp_pkg::esc_e          phase_q, phase_d;
  logic                   value_q, value_d;
  logic [7:0]             held_q, held_d;
  logic [3:0]             nib_q, nib_d;
  ufp_pkg::result_t [ufp_pkg::MaxResults-1:0] res;
  logic [2:0]             n;
  logic [2:0]             n_m1;
  logic                   accept;

  always_comb begin
    ufp_pkg::hex_t hx;
    logic          consumed;
    logic          closed;
    hx       = ufp_pkg::hex_decode(in_byte_i);
    consumed = 1'b0;
    closed   = 1'b0;
    res      = '0;
    n        = '0;
    phase_d  = phase_q;
    value_d  = value_q;
    held_d   = held_q;
    nib_d    = nib_q;

    unique case (phase_q)
      ufp_pkg::EscPercent: begin
        if (hx.ok) begin
          held_d   = in_byte_i;
          nib_d    = hx.val;
          phase_d  = ufp_pkg::EscDigit;
          consumed = 1'b1;
        end else begin
          res[n[1:0]] = '{ufp_pkg::CharPercent, 1'b1, value_d, 1'b0};
          n = n + 3'd1;
          phase_d = ufp_pkg::EscIdle;
        end
      end
      ufp_pkg::EscDigit: begin
        if (hx.ok) begin
          res[n[1:0]] = '{{nib_q, hx.val}, 1'b1, value_d, 1'b0};
          n = n + 3'd1;
          phase_d  = ufp_pkg::EscIdle;
          consumed = 1'b1;
        end else begin
          res[n[1:0]] = '{ufp_pkg::CharPercent, 1'b1, value_d, 1'b0};
          n = n + 3'd1;
          res[n[1:0]] = '{held_q, 1'b1, value_d, 1'b0};
          n = n + 3'd1;
          phase_d = ufp_pkg::EscIdle;
        end
      end
      default: phase_d = ufp_pkg::EscIdle;
    endcase

    if (!consumed) begin
      priority if (in_byte_i == ufp_pkg::CharPercent) begin
        phase_d = ufp_pkg::EscPercent;
      end else if (in_byte_i == ufp_pkg::CharAmp) begin
        res[n[1:0]] = '{8'h00, 1'b0, value_d, 1'b1};
        n = n + 3'd1;
        value_d = 1'b0;
        closed  = 1'b1;
      end else if (in_byte_i == ufp_pkg::CharEquals && !value_d) begin
        value_d = 1'b1;
      end else if (in_byte_i == ufp_pkg::CharPlus) begin
        res[n[1:0]] = '{ufp_pkg::CharSpace, 1'b1, value_d, 1'b0};
        n = n + 3'd1;
      end else begin
        res[n[1:0]] = '{in_byte_i, 1'b1, value_d, 1'b0};
        n = n + 3'd1;
      end
    end

    if (in_eod_i) begin
      if (phase_d != ufp_pkg::EscIdle) begin
        res[n[1:0]] = '{ufp_pkg::CharPercent, 1'b1, value_d, 1'b0};
        n = n + 3'd1;
        if (phase_d == ufp_pkg::EscDigit) begin
          res[n[1:0]] = '{held_d, 1'b1, value_d, 1'b0};
          n = n + 3'd1;
        end
      end
      if (!closed) begin
        res[n[1:0]] = '{8'h00, 1'b0, value_d, 1'b1};
        n = n + 3'd1;
      end
      phase_d = ufp_pkg::EscIdle;
      value_d = 1'b0;
    end
  end

  assign in_ready_o        = !full_i;
  assign accept            = in_valid_i && in_ready_o;
  assign n_m1              = n - 3'd1;
  assign push_o            = accept && (n != 3'd0);
  assign bundle_o.last_idx = n_m1[ufp_pkg::IdxW-1:0];
  assign bundle_o.res      = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ufp_pkg::EscIdle;
      value_q <= 1'b0;
    end else if (accept) begin
      phase_q <= phase_d;
      value_q <= value_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      held_q <= held_d;
      nib_q  <= nib_d;
    end
  end

endmodule

@@ rtl/ufp_queue.sv @@
// Short bundle queue between the front and back ends of the form parser.
// Depends on ufp_pkg.
module ufp_queue #(
  parameter int unsigned Depth = ufp_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  ufp_pkg::bundle_t data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output ufp_pkg::bundle_t data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  ufp_pkg::bundle_t mem [Depth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == LastPtr) ? '0 : wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == LastPtr) ? '0 : rd_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("push into a full bundle queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i) else $error("pop from an empty bundle queue");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FullCnt) else $error("bundle queue count out of range");

endmodule

@@ rtl/ufp_back.sv @@
// Back end: walks the head bundle one result per beat into the output
// register and marks the last result of each input beat. Depends on ufp_pkg, ufp_if.
module ufp_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  ufp_pkg::bundle_t head_i,
  output logic             pop_o,
  ufp_out_if.source        out_o
);

  logic [ufp_pkg::IdxW-1:0] idx_q;
  logic                     valid_q;
  ufp_pkg::result_t         res_q;
  logic                     last_q;
  logic                     load;
  logic                     take;

  assign load  = !valid_q || out_o.ready;
  assign take  = load && !empty_i;
  assign pop_o = take && (idx_q == head_i.last_idx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      if (load) begin
        valid_q <= !empty_i;
      end
      if (take) begin
        idx_q <= pop_o ? '0 : idx_q + ufp_pkg::IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q  <= head_i.res[idx_q];
      last_q <= pop_o;
    end
  end

  assign out_o.valid    = valid_q;
  assign out_o.out_byte = res_q.out_byte;
  assign out_o.has_byte = res_q.has_byte;
  assign out_o.in_value = res_q.in_value;
  assign out_o.pair_end = res_q.pair_end;
  assign out_o.run_last = last_q;

  a_idx_in_bundle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_i |-> idx_q <= head_i.last_idx) else $error("result index past bundle end");
  a_idx_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_i |-> idx_q == '0) else $error("result index not cleared with empty queue");
  a_pop_marks_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> valid_q && last_q) else $error("bundle popped without a last beat");

endmodule

@@ rtl/urlencoded_form_parser_unit.sv @@
// URL-encoded (form/query) parser, top level.
// Input channel in_i: one raw byte per beat with end_of_data on the final byte
// of a message. Output channel out_o: one decoded result per beat; a byte
// result has has_byte set, a pair-end result has pair_end set, and run_last
// marks the last result caused by an input beat. An input beat that causes no
// result (a '%', a held hex digit, the first '=' of a pair) yields no beat.
// Path: an input beat's results pass the bundle queue, then the output
// register. Throughput: one input beat per cycle while each causes at most
// one result and the receiver takes every beat; the output register emits
// one result per cycle while the receiver is ready. The front end decodes a
// beat combinationally and writes a bundle of up to four results into a
// QueueDepth-entry queue; input ready drops only when that queue is full.
// Reset clears the escape state, the key/value state, the queue and the output
// valid flag. When the receiver stalls, the output holds its beat, the queue
// fills, and then input ready falls until space frees up.
// Depends on ufp_pkg, ufp_if, ufp_front, ufp_queue, ufp_back.
module urlencoded_form_parser_unit #(
  parameter int unsigned QueueDepth = ufp_pkg::QueueDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ufp_in_if.sink    in_i,
  ufp_out_if.source out_o
);

  logic             push;
  logic             pop;
  logic             full;
  logic             empty;
  ufp_pkg::bundle_t push_bundle;
  ufp_pkg::bundle_t head_bundle;

  ufp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_byte_i  (in_i.in_byte),
    .in_eod_i   (in_i.end_of_data),
    .in_ready_o (in_i.ready),
    .full_i     (full),
    .push_o     (push),
    .bundle_o   (push_bundle)
  );

  ufp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_bundle),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (head_bundle)
  );

  ufp_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .head_i  (head_bundle),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule
